// File: rtl/p2mn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2mn_pkg
// shared constants and helpers for the period to midi note converter
// ----------------------------------------------------------------------------
package p2mn_pkg;

    localparam int unsigned PERIOD_BITS_DEF   = 18;
    localparam int unsigned LOG_FRAC_BITS_DEF = 20;

    // channel kinds
    localparam logic [3:0] KIND_SQUARE    = 4'd0;
    localparam logic [3:0] KIND_TRIANGLE  = 4'd1;
    localparam logic [3:0] KIND_PULSE6    = 4'd2;
    localparam logic [3:0] KIND_SAW6      = 4'd3;
    localparam logic [3:0] KIND_FMWAVE    = 4'd4;
    localparam logic [3:0] KIND_WAVETABLE = 4'd5;
    localparam logic [3:0] KIND_PSG       = 4'd6;

    // register indexes
    localparam logic [1:0] REG_PAL_CLOCK = 2'd0;
    localparam logic [1:0] REG_WT_CHANS  = 2'd1;
    localparam logic [1:0] REG_NOTE_ADJ  = 2'd2;

    // clock constants for the log of the master clock
    localparam logic [63:0] NTSC_NUM     = 64'd1789772727273;
    localparam logic [63:0] NTSC_DEN_440 = 64'd440000000;
    localparam logic [63:0] PAL_NUM      = 64'd1662607;
    localparam logic [63:0] A4_HZ        = 64'd440;
    localparam logic [63:0] FM_DIV       = 64'd1048576;
    localparam logic [63:0] WT_DIV_UNIT  = 64'd983040;

    // elaboration-time log2, same truncation as the hardware unit
    function automatic longint log2_const(input logic [63:0] x, input int fb);
        int          e;
        logic [63:0] m;
        longint      r;
        logic [127:0] sq;
        e = 63;
        m = '0;
        r = 0;
        sq = '0;
        if (x == 0) return 0;
        while (x[e] == 1'b0) e--;
        if (e >= 31) m = x >> (e - 31);
        else m = x << (31 - e);
        r = longint'(e) <<< fb;
        for (int i = fb - 1; i >= 0; i--) begin
            sq = m * m;
            m  = sq[94:31];
            if (m[32]) begin
                m = m >> 1;
                r = r + (longint'(1) <<< i);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/p2mn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2mn_in_if / p2mn_out_if
// valid/ready channels carrying the converter transactions
// ----------------------------------------------------------------------------
interface p2mn_in_if #(parameter int unsigned PERIOD_BITS = 18);
    logic                   valid;
    logic                   ready;
    logic [3:0]             channel_kind;
    logic [PERIOD_BITS-1:0] period;
    modport source (output valid, channel_kind, period, input ready);
    modport sink   (input valid, channel_kind, period, output ready);
endinterface

interface p2mn_out_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [6:0]         note;
    logic signed [13:0] fine_cents;
    modport source (output valid, valid_res, note, fine_cents, input ready);
    modport sink   (input valid, valid_res, note, fine_cents, output ready);
endinterface

// File: rtl/period_to_midi_note.sv
`timescale 1ns / 1ps
// an input transaction passes the log2 pipeline, then stages A, B, C and the output register
// throughput: one transaction per cycle unless the output stalls; one log2 fraction bit per stage
// a stall on the output freezes the whole pipeline, nothing is lost or repeated
// i_rst_n is synchronous active low: clears valid bits and the config registers
// config resets to ntsc clock, one wavetable channel, zero note adjust
// ----------------------------------------------------------------------------
// period_to_midi_note
// converts a sound-chip tone period into the nearest midi note and cents offset
// ----------------------------------------------------------------------------
module period_to_midi_note #(
    parameter int unsigned PERIOD_BITS   = p2mn_pkg::PERIOD_BITS_DEF,
    parameter int unsigned LOG_FRAC_BITS = p2mn_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    p2mn_in_if.sink     i_in,
    p2mn_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import p2mn_pkg::*;

    localparam int unsigned FB = LOG_FRAC_BITS;
    // log input width: period+1 times 32 fits in PERIOD_BITS+6
    localparam int unsigned XB = PERIOD_BITS + 6;
    localparam int unsigned EB = $clog2(XB);
    localparam int unsigned LB = EB + FB;
    localparam int unsigned SH = FB - 16;
    // half of the step dropped when going down to q16, none when nothing is dropped
    localparam longint RND_HALF = (longint'(1) <<< SH) >>> 1;
    // signed sum width, wide enough for 12 times the log terms
    localparam int unsigned SB = FB + 14;

    localparam longint LC_NTSC = log2_const(NTSC_NUM, FB) - log2_const(NTSC_DEN_440, FB);
    localparam longint LC_PAL  = log2_const(PAL_NUM, FB) - log2_const(A4_HZ, FB);
    localparam longint L_FM    = log2_const(FM_DIV, FB);
    localparam longint L_WT1   = log2_const(WT_DIV_UNIT, FB);
    localparam longint L_WT2   = log2_const(WT_DIV_UNIT * 2, FB);
    localparam longint L_WT3   = log2_const(WT_DIV_UNIT * 3, FB);
    localparam longint L_WT4   = log2_const(WT_DIV_UNIT * 4, FB);
    localparam longint L_WT5   = log2_const(WT_DIV_UNIT * 5, FB);
    localparam longint L_WT6   = log2_const(WT_DIV_UNIT * 6, FB);
    localparam longint L_WT7   = log2_const(WT_DIV_UNIT * 7, FB);
    localparam longint L_WT8   = log2_const(WT_DIV_UNIT * 8, FB);

    typedef struct packed {
        logic                  tonal;
        logic                  neg;      // log term subtracted
        logic signed [SB-1:0]  offs;     // clock log, minus the divisor log for fm and wavetable kinds
        logic signed [8:0]     adj;
    } t_tag;
    localparam int unsigned TB = $bits(t_tag);

    // ---------------- configuration registers ----------------
    logic       r_pal;
    logic [3:0] r_wt_chans;
    logic [7:0] r_note_adj;
    logic [1:0] w_reg_idx;

    assign w_reg_idx = paddr[3:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal      <= 1'b0;
            r_wt_chans <= 4'd1;
            r_note_adj <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                REG_PAL_CLOCK: r_pal      <= pwdata[0];
                REG_WT_CHANS:  r_wt_chans <= pwdata[3:0];
                REG_NOTE_ADJ:  r_note_adj <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_PAL_CLOCK: prdata = {31'd0, r_pal};
            REG_WT_CHANS:  prdata = {28'd0, r_wt_chans};
            REG_NOTE_ADJ:  prdata = {24'd0, r_note_adj};
            default:       prdata = '0;
        endcase
    end

    // ---------------- pipeline enable ----------------
    // whole pipeline advances when the output register is free or drained
    logic r_ov;
    logic w_en;
    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- stage 0: select log argument ----------------
    logic [PERIOD_BITS-1:0] w_p;
    logic [XB-1:0]          w_p1;
    logic [XB-1:0]          w_x;
    logic [3:0]             w_n;
    longint                 w_lwt;
    longint                 w_lc;
    t_tag                   w_tag;

    assign w_p  = i_in.period;
    assign w_p1 = XB'(w_p) + XB'(1);

    always_comb begin
        w_n = r_wt_chans;
        if (w_n == 4'd0) w_n = 4'd1;
        if (w_n > 4'd8)  w_n = 4'd8;
        unique case (w_n)
            4'd1:    w_lwt = L_WT1;
            4'd2:    w_lwt = L_WT2;
            4'd3:    w_lwt = L_WT3;
            4'd4:    w_lwt = L_WT4;
            4'd5:    w_lwt = L_WT5;
            4'd6:    w_lwt = L_WT6;
            4'd7:    w_lwt = L_WT7;
            default: w_lwt = L_WT8;
        endcase
        w_lc = r_pal ? LC_PAL : LC_NTSC;

        w_tag.tonal = (w_p != '0) && (i_in.channel_kind <= KIND_PSG);
        w_tag.neg   = 1'b1;
        w_tag.offs  = SB'(w_lc);
        w_tag.adj   = 9'(signed'(r_note_adj));
        // the x16, x32 and x14 factors are folded into the log input
        unique case (i_in.channel_kind)
            KIND_SQUARE, KIND_PULSE6: w_x = w_p1 << 4;
            KIND_TRIANGLE:            w_x = w_p1 << 5;
            KIND_SAW6:                w_x = (w_p1 << 4) - (w_p1 << 1);
            KIND_FMWAVE: begin
                w_x         = XB'(w_p);
                w_tag.neg   = 1'b0;
                w_tag.offs  = SB'(w_lc - L_FM);
            end
            KIND_WAVETABLE: begin
                w_x         = XB'(w_p);
                w_tag.neg   = 1'b0;
                w_tag.offs  = SB'(w_lc - w_lwt);
            end
            default:                  w_x = XB'(w_p) << 5;
        endcase
    end

    // ---------------- log2 pipeline ----------------
    logic          w_lv;
    logic [LB-1:0] w_log;
    logic [TB-1:0] w_ltag;

    p2mn_log2 #(
        .IN_BITS   (XB),
        .FRAC_BITS (FB),
        .TAG_BITS  (TB)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_x     (w_x),
        .i_tag   (w_tag),
        .o_valid (w_lv),
        .o_log   (w_log),
        .o_tag   (w_ltag)
    );

    // ---------------- stage A: total log ----------------
    t_tag                  w_lt;
    logic signed [SB-1:0]  w_lsum;
    logic                  r_av;
    logic signed [SB-1:0]  r_lsum;
    t_tag                  r_at;

    assign w_lt   = t_tag'(w_ltag);
    assign w_lsum = w_lt.neg ? w_lt.offs - SB'(w_log) : w_lt.offs + SB'(w_log);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (w_en) r_av <= w_lv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lsum <= w_lsum;
            r_at   <= w_lt;
        end
    end

    // ---------------- stage B: note in q16 ----------------
    logic signed [SB+3:0]  w_x12;
    logic signed [SB+3:0]  w_rnd;
    logic signed [SB+3:0]  w_q;
    logic                  r_bv;
    logic signed [SB+3:0]  r_nq;
    logic                  r_btonal;

    // 12 times the log, rounded half up into q16
    assign w_x12 = (SB+4)'(r_lsum) * (SB+4)'(12);
    assign w_rnd = (w_x12 + (SB+4)'(RND_HALF)) >>> SH;
    assign w_q   = w_rnd + ((SB+4)'(69) <<< 16) + ((SB+4)'(r_at.adj) <<< 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (w_en) r_bv <= r_av;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nq     <= w_q;
            r_btonal <= r_at.tonal;
        end
    end

    // ---------------- stage C: round and split ----------------
    logic                  w_qneg;
    logic [SB+3:0]         w_qabs;
    logic [SB+3:0]         w_rabs;
    logic signed [SB+3:0]  w_nr;
    logic signed [16:0]    w_frac;
    logic                  r_cv;
    logic signed [SB+3:0]  r_nr;
    logic signed [16:0]    r_frac;
    logic                  r_ctonal;

    assign w_qneg = r_nq < 0;
    assign w_qabs = w_qneg ? -r_nq : r_nq;
    assign w_rabs = (w_qabs + (SB+4)'(32768)) >> 16;
    assign w_nr   = w_qneg ? -signed'(w_rabs) : signed'(w_rabs);
    assign w_frac = 17'(r_nq - (w_nr <<< 16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (w_en) r_cv <= r_bv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nr     <= w_nr;
            r_frac   <= w_frac;
            r_ctonal <= r_btonal;
        end
    end

    // ---------------- stage D: cents and clamp, output register ----------------
    logic signed [31:0] w_num;
    logic [31:0]        w_nabs;
    logic [15:0]        w_cabs;
    logic [6:0]         w_nc;
    logic signed [13:0] w_cents;
    logic               r_res;
    logic [6:0]         r_note;
    logic signed [13:0] r_cents;

    assign w_num   = 32'(r_frac) * 32'sd10000;
    assign w_nabs  = (w_num < 0) ? 32'(-w_num) : 32'(w_num);
    assign w_cabs  = 16'((w_nabs + 32'd32768) >> 16);
    assign w_cents = (w_num < 0) ? -14'(w_cabs) : 14'(w_cabs);
    assign w_nc    = (r_nr < 0) ? 7'd0 : (r_nr > 127) ? 7'd127 : 7'(r_nr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r_cv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res   <= r_ctonal;
            r_note  <= r_ctonal ? w_nc : 7'd0;
            r_cents <= r_ctonal ? w_cents : 14'sd0;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.valid_res  = r_res;
    assign o_out.note       = r_note;
    assign o_out.fine_cents = r_cents;

    // ---------------- assertions ----------------
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=> r_ov && $stable(r_note) && $stable(r_cents))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!r_ov || o_out.ready))
        else $error("input ready not tied to output drain");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_res |-> r_note == 7'd0 && r_cents == 14'sd0)
        else $error("non-tonal result not zeroed");
    a_cents_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_res |-> r_cents <= 14'sd5000 && r_cents >= -14'sd5000)
        else $error("cents out of range");
endmodule

// File: rtl/p2mn_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2mn_log2
// pipelined fixed-point log2, one fraction bit per stage
// ----------------------------------------------------------------------------
module p2mn_log2 #(
    parameter int unsigned IN_BITS   = 32,
    parameter int unsigned FRAC_BITS = 20,
    parameter int unsigned TAG_BITS  = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [IN_BITS-1:0]       i_x,
    input  logic [TAG_BITS-1:0]      i_tag,
    output logic                     o_valid,
    output logic [$clog2(IN_BITS)+FRAC_BITS-1:0] o_log,
    output logic [TAG_BITS-1:0]      o_tag
);
    localparam int unsigned EB = $clog2(IN_BITS);
    localparam int unsigned NS = FRAC_BITS + 1;

    logic [NS-1:0]          r_v;
    logic [32:0]            r_m   [NS];
    logic [EB+FRAC_BITS-1:0] r_r  [NS];
    logic [TAG_BITS-1:0]    r_tag [NS];

    logic [EB-1:0]  w_e;
    logic [31:0]    w_m0;
    logic [63:0]    w_sh;

    // leading one search
    always_comb begin
        w_e = '0;
        for (int i = 0; i < IN_BITS; i++) begin
            if (i_x[i]) w_e = EB'(i);
        end
        w_sh = {{(64-IN_BITS){1'b0}}, i_x} << (7'd63 - {1'b0, 6'(w_e)});
        w_m0 = w_sh[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]   <= {1'b0, w_m0};
            r_r[0]   <= {w_e, {FRAC_BITS{1'b0}}};
            r_tag[0] <= i_tag;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_stage
        logic [65:0] w_sq;
        logic [32:0] w_mn;
        assign w_sq = r_m[s-1] * r_m[s-1];
        assign w_mn = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= r_tag[s-1];
                if (w_mn[32]) begin
                    r_m[s] <= {1'b0, w_mn[32:1]};
                    r_r[s] <= r_r[s-1] | ((EB+FRAC_BITS)'(1) << (FRAC_BITS - s));
                end else begin
                    r_m[s] <= w_mn;
                    r_r[s] <= r_r[s-1];
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_log   = r_r[NS-1];
    assign o_tag   = r_tag[NS-1];
endmodule

// File: test/period_to_midi_note_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// period_to_midi_note_tb
// self-checking bench: table-driven directed tones, then random tones under
// several clock / channel-count / transpose settings, scored against an
// independent fixed-point model of the note and cents computation
// ----------------------------------------------------------------------------
module period_to_midi_note_tb;
    import p2mn_pkg::*;

    localparam int          HALF_PERIOD = 5;
    localparam int          SETTLE      = LOG_FRAC_BITS_DEF + 15;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          ITEMS_PER_PHASE = 205;
    localparam logic [3:0]  KIND_NOISE  = 4'd7;
    localparam logic [3:0]  KIND_DPCM   = 4'd8;
    localparam logic [3:0]  KIND_UNDEF  = 4'd15;
    localparam logic [17:0] PERIOD_MAX  = 18'h3ffff;

    typedef struct packed {
        logic               valid_res;
        logic [6:0]         note;
        logic signed [13:0] cents;
    } t_note_res;

    typedef struct packed {
        logic [3:0]  kind;
        logic [17:0] period;
        logic        typed;
        t_note_res   res;
    } t_tone_row;

    localparam t_note_res SILENT = '{1'b0, 7'd0, 14'sd0};
    localparam t_note_res NONE   = '0;

    // directed tones: period extremes per kind, plus the silent cases
    localparam t_tone_row TONE_TABLE [22] = '{
        '{KIND_SQUARE,    18'd0,      1'b1, SILENT},
        '{KIND_SQUARE,    18'd1,      1'b0, NONE},
        '{KIND_SQUARE,    PERIOD_MAX, 1'b0, NONE},
        '{KIND_SQUARE,    18'd253,    1'b0, NONE},
        '{KIND_TRIANGLE,  18'd1,      1'b0, NONE},
        '{KIND_TRIANGLE,  PERIOD_MAX, 1'b0, NONE},
        '{KIND_PULSE6,    18'd1,      1'b0, NONE},
        '{KIND_PULSE6,    PERIOD_MAX, 1'b0, NONE},
        '{KIND_SAW6,      18'd1,      1'b0, NONE},
        '{KIND_SAW6,      PERIOD_MAX, 1'b0, NONE},
        '{KIND_FMWAVE,    18'd1,      1'b0, NONE},
        '{KIND_FMWAVE,    PERIOD_MAX, 1'b0, NONE},
        '{KIND_WAVETABLE, 18'd1,      1'b0, NONE},
        '{KIND_WAVETABLE, PERIOD_MAX, 1'b0, NONE},
        '{KIND_PSG,       18'd1,      1'b0, NONE},
        '{KIND_PSG,       PERIOD_MAX, 1'b0, NONE},
        '{KIND_PSG,       18'd0,      1'b1, SILENT},
        '{KIND_NOISE,     18'd100,    1'b1, SILENT},
        '{KIND_DPCM,      PERIOD_MAX, 1'b1, SILENT},
        '{KIND_UNDEF,     18'd513,    1'b1, SILENT},
        '{4'd9,           18'd1,      1'b1, SILENT},
        '{KIND_TRIANGLE,  18'd0,      1'b1, SILENT}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    p2mn_in_if #(.PERIOD_BITS(18)) tone_ch ();
    p2mn_out_if                    note_ch ();

    period_to_midi_note u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tone_ch),
        .o_out   (note_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the config registers
    logic              cfg_pal;
    logic [3:0]        cfg_chans;
    logic signed [7:0] cfg_adjust;

    t_note_res pending_notes[$];
    int        mismatches;
    int        tones_sent;
    int        notes_checked;
    int        cycles;
    int        burst_left;
    int        stall_left;
    logic      tone_took;

    always #HALF_PERIOD i_clk = ~i_clk;

    // log2 of a positive integer in q20, truncating each squaring step
    function automatic longint log2_q20(input logic [63:0] x);
        int          msb;
        logic [63:0] mant;
        longint      acc;
        msb  = 63;
        mant = '0;
        acc  = 0;
        if (x == 0) return 0;
        while (!x[msb]) msb--;
        mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
        acc  = longint'(msb) <<< LOG_FRAC_BITS_DEF;
        for (int b = LOG_FRAC_BITS_DEF - 1; b >= 0; b--) begin
            mant = (mant * mant) >> 31;
            if (mant[32]) begin
                mant = mant >> 1;
                acc  = acc + (longint'(1) <<< b);
            end
        end
        return acc;
    endfunction

    // expected note and cents for one tone under the shadow config
    function automatic t_note_res predict_note(input logic [3:0] kind,
                                               input logic [17:0] period);
        longint      l_clk, l_kind, note_q, rounded, frac_part, scaled, cents, p;
        logic [63:0] chans;
        t_note_res   res;
        res = '0;
        p   = longint'(period);
        if (period == 0 || kind > KIND_PSG) return res;
        if (cfg_pal) l_clk = log2_q20(PAL_NUM) - log2_q20(A4_HZ);
        else         l_clk = log2_q20(NTSC_NUM) - log2_q20(NTSC_DEN_440);
        chans = (cfg_chans < 1) ? 64'd1 : (cfg_chans > 8) ? 64'd8 : 64'(cfg_chans);
        case (kind)
            KIND_SQUARE, KIND_PULSE6: l_kind = -log2_q20(16 * (p + 1));
            KIND_TRIANGLE:            l_kind = -log2_q20(32 * (p + 1));
            KIND_SAW6:                l_kind = -log2_q20(14 * (p + 1));
            KIND_FMWAVE:              l_kind = log2_q20(p) - log2_q20(FM_DIV);
            KIND_WAVETABLE:           l_kind = log2_q20(p) - log2_q20(chans * WT_DIV_UNIT);
            default:                  l_kind = -log2_q20(32 * p);
        endcase
        // 12*log2 from q20 down to q16, rounded half up
        note_q = 69 * 65536 + ((12 * (l_clk + l_kind) + 8) >>> 4)
                 + longint'(cfg_adjust) * 65536;
        // note rounded half away from zero
        rounded = (note_q >= 0) ? ((note_q + 32768) >>> 16) : -((32768 - note_q) >>> 16);
        frac_part = note_q - rounded * 65536;
        scaled    = frac_part * 10000;
        cents = (scaled >= 0) ? ((scaled + 32768) >>> 16) : -((32768 - scaled) >>> 16);
        res.valid_res = 1'b1;
        res.note      = (rounded < 0) ? 7'd0 : (rounded > 127) ? 7'd127 : rounded[6:0];
        res.cents     = cents[13:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // input acceptance and output scoring, both sampled at the rising edge
    always @(posedge i_clk) begin
        t_note_res want;
        cycles    <= cycles + 1;
        tone_took <= tone_ch.valid && tone_ch.ready;
        if (note_ch.valid && note_ch.ready) begin
            if (pending_notes.size() == 0) begin
                report_mismatch("note transaction with nothing expected");
            end else begin
                want = pending_notes.pop_front();
                notes_checked++;
                if (note_ch.valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res %b, want %b",
                                              note_ch.valid_res, want.valid_res));
                if (note_ch.note !== want.note)
                    report_mismatch($sformatf("note %0d, want %0d",
                                              note_ch.note, want.note));
                if (note_ch.fine_cents !== want.cents)
                    report_mismatch($sformatf("fine_cents %0d, want %0d",
                                              note_ch.fine_cents, want.cents));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d notes outstanding",
                     cycles, pending_notes.size());
            $display("** period_to_midi_note: FAILED **");
            $finish;
        end
    end

    // receiver: stretches of full throughput, random stalls, long holds
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            note_ch.ready = 1'b0;
        end else begin
            note_ch.ready = 1'b1;
            case ($urandom_range(0, 99))
                0, 1:    stall_left = $urandom_range(5, 30);
                2, 3, 4,
                5, 6, 7: stall_left = $urandom_range(1, 3);
                default: stall_left = 0;
            endcase
        end
    end

    // one tone transaction; the sender works in bursts with idle gaps
    task automatic send_tone(input logic [3:0] kind, input logic [17:0] period,
                             input logic typed, input t_note_res typed_res);
        t_note_res want;
        if (burst_left == 0) begin
            tone_ch.valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        want = typed ? typed_res : predict_note(kind, period);
        tone_ch.valid        = 1'b1;
        tone_ch.channel_kind = kind;
        tone_ch.period       = period;
        do @(negedge i_clk); while (!tone_took);
        pending_notes.push_back(want);
        tones_sent++;
        burst_left--;
    endtask

    // hold off until every pending note is out and the pipeline has emptied
    task automatic drain_notes();
        tone_ch.valid = 1'b0;
        burst_left    = 0;
        while (pending_notes.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(negedge i_clk); while (!pready);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_PAL_CLOCK: cfg_pal    = value[0];
            REG_WT_CHANS:  cfg_chans  = value[3:0];
            default:       cfg_adjust = value[7:0];
        endcase
    endtask

    task automatic set_config(input logic pal, input logic [3:0] chans,
                              input logic [7:0] adjust);
        write_reg(REG_PAL_CLOCK, {31'd0, pal});
        write_reg(REG_WT_CHANS,  {28'd0, chans});
        write_reg(REG_NOTE_ADJ,  {24'd0, adjust});
    endtask

    // mostly tonal kinds, periods spread over every bit width
    task automatic random_tones(input int count);
        logic [3:0]  kind;
        logic [17:0] period;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(7, 15))
                                               : 4'($urandom_range(0, 6));
            case ($urandom_range(0, 3))
                0:       period = 18'($urandom);
                1:       period = 18'($urandom_range(0, 15));
                2:       period = PERIOD_MAX - 18'($urandom_range(0, 31));
                default: period = 18'($urandom) & 18'((1 << $urandom_range(1, 18)) - 1);
            endcase
            send_tone(kind, period, 1'b0, NONE);
        end
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        tone_ch.valid        = 1'b0;
        tone_ch.channel_kind = '0;
        tone_ch.period       = '0;
        note_ch.ready        = 1'b1;
        cfg_pal              = 1'b0;
        cfg_chans            = 4'd1;
        cfg_adjust           = 8'sd0;
        mismatches           = 0;
        tones_sent           = 0;
        notes_checked        = 0;
        cycles               = 0;
        burst_left           = 0;
        stall_left           = 0;
        tone_took            = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed tones at reset config
        foreach (TONE_TABLE[r])
            send_tone(TONE_TABLE[r].kind, TONE_TABLE[r].period,
                      TONE_TABLE[r].typed, TONE_TABLE[r].res);
        drain_notes();

        // random tones under a sweep of settings, extremes included
        set_config(1'b1, 4'd8, 8'sd127);
        random_tones(ITEMS_PER_PHASE);
        drain_notes();
        set_config(1'b0, 4'd0, -8'sd127);
        random_tones(ITEMS_PER_PHASE);
        drain_notes();
        set_config(1'b1, 4'd15, 8'h80);
        random_tones(ITEMS_PER_PHASE);
        drain_notes();
        set_config(1'b0, 4'd9, 8'sd12);
        random_tones(ITEMS_PER_PHASE);
        drain_notes();
        set_config(1'b1, 4'd3, -8'sd24);
        random_tones(ITEMS_PER_PHASE);
        drain_notes();
        set_config(1'b0, 4'd1, 8'sd0);
        random_tones(ITEMS_PER_PHASE);
        drain_notes();
        set_config(1'($urandom), 4'($urandom), 8'($urandom));
        random_tones(ITEMS_PER_PHASE);
        drain_notes();
        set_config(1'b0, 4'd5, -8'sd1);
        random_tones(ITEMS_PER_PHASE);
        drain_notes();

        $display("%0d tone transactions over 9 register settings, %0d note transactions scored",
                 tones_sent, notes_checked);
        $display("%0d mismatches, %0d cycles", mismatches, cycles);
        if (mismatches == 0 && pending_notes.size() == 0) begin
            $display("** period_to_midi_note: PASSED **");
        end else begin
            $display("** period_to_midi_note: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/p2mn_pkg.sv
rtl/p2mn_if.sv
rtl/p2mn_log2.sv
rtl/period_to_midi_note.sv
test/period_to_midi_note_tb.sv
